// File: hdl/gpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller package
// Shared constants, codes and types of the GPIO pad controller.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int NUM_PADS   = 128;
   localparam int PAD_W      = $clog2(NUM_PADS);
   localparam int PADF_W     = 7;
   localparam int STAT_WORDS = 4;
   localparam int STAT_USED  = (NUM_PADS + 31) / 32;

   localparam int CONF_LVL_BIT    = 24;
   localparam int CONF_POS_BIT    = 25;
   localparam int CONF_NEG_BIT    = 26;
   localparam int VAL_IN_EN_N_BIT = 2;
   localparam int VAL_LEVEL_BIT   = 0;

   localparam logic [3:0] REG_CONFIG = 4'h0;
   localparam logic [3:0] REG_EXTRA  = 4'h4;
   localparam logic [3:0] REG_VALUE  = 4'h8;
   localparam logic [2:0] VAL_RESET  = 3'd6;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic [31:0] cfg_word;
      logic [31:0] extra_word;
      logic [2:0]  value;
      logic        last_level;
   } row_type;

   localparam row_type ROW_RESET = '{cfg_word: 32'd0, extra_word: 32'd0,
                                     value: VAL_RESET, last_level: 1'b0};

endpackage

// File: hdl/gpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller sequencer
// Steps each accepted word through pad row lookup and update, and strobes
// the result.
// ----------------------------------------------------------------------------
module gpc_ctrl
   import gpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
               busy_in  = 1'b1;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in     = ST_IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.capture = start && (state_ff == ST_IDLE);
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;

endmodule

// File: hdl/gpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller datapath
// Pad row memory with valid bits, interrupt status words, address decode
// and the result registers.
// ----------------------------------------------------------------------------
module gpc_datapath
   import gpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [6:0]  req_pad_index,
   input  logic        req_pad_level,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_pending,
   output logic        rsp_bad_address
);

   op_type                        op_ff;
   logic [11:0]                   addr_ff;
   logic [31:0]                   data_ff;
   logic [PADF_W-1:0]             pad_ff;
   logic                          level_ff;

   row_type                       mem [NUM_PADS];
   row_type                       rd_row_ff;
   logic [NUM_PADS-1:0]           valid_ff;
   logic [STAT_WORDS-1:0][31:0]   status_ff, status_in;

   logic [31:0]                   read_data_ff, read_data_in;
   logic                          irq_ff;
   logic                          bad_ff, bad_in;

   row_type                       row_cur, row_in;
   logic                          row_we;
   logic [PAD_W-1:0]              row_idx;
   logic                          pad_ok;
   logic [8:0]                    stat_word;
   logic                          stat_ok;
   logic [1:0]                    stat_idx;
   logic [2:0]                    value_rd;
   logic                          hit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         addr_ff  <= req_address;
         data_ff  <= req_write_data;
         level_ff <= req_pad_level;
         if (op_type'(req_operation) == OP_SAMPLE) begin
            pad_ff <= req_pad_index;
         end else begin
            pad_ff <= req_address[10:4];
         end
      end
   end

   assign row_idx   = pad_ff[PAD_W-1:0];
   assign pad_ok    = {1'b0, pad_ff} < (PADF_W + 1)'(NUM_PADS);
   assign stat_word = addr_ff[10:2];
   assign stat_ok   = {1'b0, stat_word} < 10'(STAT_USED);
   assign stat_idx  = stat_word[1:0];
   assign row_cur   = valid_ff[row_idx] ? rd_row_ff : ROW_RESET;

   always_comb begin
      value_rd = row_cur.value;
      if (!row_cur.value[VAL_IN_EN_N_BIT]) begin
         value_rd[VAL_LEVEL_BIT] = row_cur.last_level;
      end
      if (row_cur.cfg_word[CONF_LVL_BIT]) begin
         hit = (row_cur.cfg_word[CONF_POS_BIT] && level_ff) ||
               (row_cur.cfg_word[CONF_NEG_BIT] && !level_ff);
      end else begin
         hit = (row_cur.cfg_word[CONF_POS_BIT] && !row_cur.last_level && level_ff) ||
               (row_cur.cfg_word[CONF_NEG_BIT] && row_cur.last_level && !level_ff);
      end
   end

   always_comb begin
      row_in       = row_cur;
      row_we       = 1'b0;
      status_in    = status_ff;
      read_data_in = 32'd0;
      bad_in       = 1'b0;
      case (op_ff)
         OP_READ, OP_WRITE: begin
            if (addr_ff[1:0] != 2'b00) begin
               bad_in = 1'b1;
            end else if (addr_ff[11]) begin
               if (!stat_ok) begin
                  bad_in = 1'b1;
               end else if (op_ff == OP_WRITE) begin
                  status_in[stat_idx] = status_ff[stat_idx] & ~data_ff;
               end else begin
                  read_data_in = status_ff[stat_idx];
               end
            end else if (!pad_ok) begin
               bad_in = 1'b1;
            end else begin
               case (addr_ff[3:0])
                  REG_CONFIG: begin
                     row_in.cfg_word = data_ff;
                     read_data_in    = row_cur.cfg_word;
                  end
                  REG_EXTRA: begin
                     row_in.extra_word = data_ff;
                     read_data_in      = row_cur.extra_word;
                  end
                  REG_VALUE: begin
                     row_in.value = data_ff[2:0];
                     read_data_in = {29'd0, value_rd};
                  end
                  default: begin
                     bad_in = 1'b1;
                  end
               endcase
               row_we = (op_ff == OP_WRITE) && !bad_in;
               if (op_ff == OP_WRITE) begin
                  read_data_in = 32'd0;
               end
            end
         end
         OP_SAMPLE: begin
            if (pad_ok) begin
               if (hit) begin
                  status_in[pad_ff[6:5]][pad_ff[4:0]] = 1'b1;
               end
               row_in.last_level = level_ff;
               row_we            = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_row_ff <= mem[row_idx];
      end
      if (cmd.update && row_we) begin
         mem[row_idx] <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         status_ff <= '0;
      end else if (cmd.update) begin
         status_ff <= status_in;
         if (row_we) begin
            valid_ff[row_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         read_data_ff <= read_data_in;
         bad_ff       <= bad_in;
         irq_ff       <= |status_in;
      end
   end

   assign rsp_read_data   = read_data_ff;
   assign rsp_irq_pending = irq_ff;
   assign rsp_bad_address = bad_ff;

endmodule

// File: hdl/gpio_pad_controller_with_irq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller with interrupt status
// Per-pad configuration, value and edge/level interrupt status behind a
// register bus, with pad level samples on the same command port.
// ----------------------------------------------------------------------------
// Each word passes the lookup state, which reads the pad row memory, and the
// update state, which writes it; the registered result strobe follows, in a
// cycle in which the next word can already be accepted. The row memory is
// read and written once per word, and busy holds through both states. The
// result is on the rsp_ ports for exactly one cycle and the receiver cannot
// stall it. Reset takes effect at once; no memory clearing pass is needed.
module gpio_pad_controller_with_irq_core
   import gpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [6:0]  req_pad_index,
   input  logic        req_pad_level,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_pending,
   output logic        rsp_bad_address
);

   cmd_type cmd;

   gpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   gpc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_pad_index   (req_pad_index),
      .req_pad_level   (req_pad_level),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_bad_address (rsp_bad_address)
   );

endmodule

// File: hdl/gpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller port checker
// Checks the command and result timing seen at the top level ports.
// ----------------------------------------------------------------------------
module gpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_read_data,
   input logic        rsp_bad_address
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_address) |-> (rsp_read_data == 32'd0))
      else $error("bad address with nonzero read data");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule

bind gpio_pad_controller_with_irq_core gpc_checker u_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pad controller testbench
// Drives bus reads, bus writes and pad samples into the controller and checks
// every response word against a cycle-free model of the pad registers and
// interrupt status. Directed tests cover reset values, register access, bad
// addresses and the edge and level triggers; a random test follows.
// ----------------------------------------------------------------------------
module tb
   import gpc_pkg::*;
();

   localparam logic [11:0] STAT_BASE   = 12'h800;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_WAIT  = 8;

   typedef struct {
      op_type      op;
      logic [11:0] addr;
      logic [31:0] data;
      logic [6:0]  pad;
      logic        lvl;
   } gpio_word_type;

   typedef struct {
      logic [31:0] read_data;
      logic        irq_pending;
      logic        bad_address;
   } gpio_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [11:0] req_address;
   logic [31:0] req_write_data;
   logic [6:0]  req_pad_index;
   logic        req_pad_level;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_pending;
   logic        rsp_bad_address;

   logic [31:0] conf_mem  [NUM_PADS];
   logic [31:0] extra_mem [NUM_PADS];
   logic [2:0]  value_mem [NUM_PADS];
   logic        last_lvl  [NUM_PADS];
   logic [31:0] stat_mem  [STAT_WORDS];

   gpio_rsp_type gpio_rsp_q [$];
   gpio_rsp_type want_rsp;

   int fail_count;
   int cycle_count;
   int n_reads;
   int n_writes;
   int n_samples;
   int n_other;
   int n_irq_hits;

   gpio_pad_controller_with_irq_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_pad_index   (req_pad_index),
      .req_pad_level   (req_pad_level),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_bad_address (rsp_bad_address)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic gpio_rsp_type compute_gpio_rsp(input gpio_word_type w);
      gpio_rsp_type r;
      int          word_idx;
      int          p;
      logic [3:0]  reg_off;
      logic [31:0] conf;
      logic [2:0]  v;
      logic        hit;
      r.read_data   = 32'd0;
      r.bad_address = 1'b0;
      if (w.op == OP_READ || w.op == OP_WRITE) begin
         if (w.addr[1:0] != 2'b00) begin
            r.bad_address = 1'b1;
         end else if (w.addr >= STAT_BASE) begin
            word_idx = int'((w.addr - STAT_BASE) >> 2);
            if (word_idx >= STAT_USED || word_idx >= STAT_WORDS) begin
               r.bad_address = 1'b1;
            end else if (w.op == OP_WRITE) begin
               stat_mem[word_idx] = stat_mem[word_idx] & ~w.data;
            end else begin
               r.read_data = stat_mem[word_idx];
            end
         end else begin
            p       = int'(w.addr >> 4);
            reg_off = w.addr[3:0];
            if (p >= NUM_PADS) begin
               r.bad_address = 1'b1;
            end else if (reg_off == REG_CONFIG) begin
               if (w.op == OP_WRITE) conf_mem[p] = w.data;
               else r.read_data = conf_mem[p];
            end else if (reg_off == REG_EXTRA) begin
               if (w.op == OP_WRITE) extra_mem[p] = w.data;
               else r.read_data = extra_mem[p];
            end else if (reg_off == REG_VALUE) begin
               if (w.op == OP_WRITE) begin
                  value_mem[p] = w.data[2:0];
               end else begin
                  v = value_mem[p];
                  if (!v[VAL_IN_EN_N_BIT]) v[VAL_LEVEL_BIT] = last_lvl[p];
                  r.read_data = {29'd0, v};
               end
            end else begin
               r.bad_address = 1'b1;
            end
         end
      end else if (w.op == OP_SAMPLE) begin
         p = int'(w.pad);
         if (p < NUM_PADS) begin
            conf = conf_mem[p];
            if (conf[CONF_LVL_BIT]) begin
               hit = (conf[CONF_POS_BIT] && w.lvl) || (conf[CONF_NEG_BIT] && !w.lvl);
            end else begin
               hit = (conf[CONF_POS_BIT] && !last_lvl[p] && w.lvl) ||
                     (conf[CONF_NEG_BIT] && last_lvl[p] && !w.lvl);
            end
            if (hit) begin
               stat_mem[p / 32][p % 32] = 1'b1;
               n_irq_hits++;
            end
            last_lvl[p] = w.lvl;
         end
      end
      r.irq_pending = 1'b0;
      for (int i = 0; i < STAT_WORDS; i++) begin
         if (stat_mem[i] != 32'd0) r.irq_pending = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (gpio_rsp_q.size() == 0) begin
            $error("response word with no expectation pending");
            fail_count++;
         end else begin
            want_rsp = gpio_rsp_q.pop_front();
            if (rsp_read_data !== want_rsp.read_data) begin
               $error("read_data expected %h actual %h", want_rsp.read_data, rsp_read_data);
               fail_count++;
            end
            if (rsp_irq_pending !== want_rsp.irq_pending) begin
               $error("irq_pending expected %b actual %b", want_rsp.irq_pending,
                      rsp_irq_pending);
               fail_count++;
            end
            if (rsp_bad_address !== want_rsp.bad_address) begin
               $error("bad_address expected %b actual %b", want_rsp.bad_address,
                      rsp_bad_address);
               fail_count++;
            end
         end
      end
   end

   task automatic send_word(input gpio_word_type w, input int gap);
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= w.op;
      req_address    <= w.addr;
      req_write_data <= w.data;
      req_pad_index  <= w.pad;
      req_pad_level  <= w.lvl;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (w.op)
         OP_READ:   n_reads++;
         OP_WRITE:  n_writes++;
         OP_SAMPLE: n_samples++;
         default:   n_other++;
      endcase
      gpio_rsp_q.push_back(compute_gpio_rsp(w));
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (gpio_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic bus_word(input op_type op, input logic [11:0] addr,
                           input logic [31:0] data);
      gpio_word_type w;
      w.op   = op;
      w.addr = addr;
      w.data = data;
      w.pad  = 7'($urandom);
      w.lvl  = 1'($urandom);
      send_word(w, 0);
   endtask

   task automatic pad_word(input logic [6:0] pad, input logic lvl);
      gpio_word_type w;
      w.op   = OP_SAMPLE;
      w.addr = 12'($urandom);
      w.data = $urandom;
      w.pad  = pad;
      w.lvl  = lvl;
      send_word(w, 0);
   endtask

   function automatic logic [6:0] pick_pad();
      case ($urandom_range(0, 7))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd31;
         3:       return 7'd32;
         4:       return 7'd63;
         5:       return 7'd64;
         6:       return 7'd100;
         default: return 7'd127;
      endcase
   endfunction

   function automatic gpio_word_type random_word();
      gpio_word_type w;
      int          sel;
      logic [6:0]  pad;
      logic [3:0]  reg_off;
      w.op    = OP_NONE;
      w.addr  = 12'($urandom);
      w.data  = $urandom;
      w.pad   = 7'($urandom);
      w.lvl   = 1'($urandom);
      sel     = $urandom_range(0, 99);
      pad     = ($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_pad();
      reg_off = ($urandom_range(0, 2) == 0) ? REG_CONFIG :
                ($urandom_range(0, 1) == 0) ? REG_EXTRA : REG_VALUE;
      if (sel < 35) begin
         w.op  = OP_SAMPLE;
         w.pad = pad;
      end else if (sel < 50) begin
         w.op   = OP_WRITE;
         w.addr = {1'b0, pad, REG_CONFIG};
      end else if (sel < 58) begin
         w.op   = OP_READ;
         w.addr = STAT_BASE + 12'(4 * $urandom_range(0, 3));
      end else if (sel < 66) begin
         w.op   = OP_WRITE;
         w.addr = STAT_BASE + 12'(4 * $urandom_range(0, 3));
         if ($urandom_range(0, 1) == 0) w.data = 32'hFFFF_FFFF;
      end else if (sel < 78) begin
         w.op   = OP_READ;
         w.addr = {1'b0, pad, reg_off};
      end else if (sel < 86) begin
         w.op   = OP_WRITE;
         w.addr = {1'b0, pad, REG_VALUE};
      end else if (sel < 90) begin
         w.op   = OP_WRITE;
         w.addr = {1'b0, pad, REG_EXTRA};
      end else begin
         w.op = op_type'(2'($urandom_range(0, 3)));
      end
      return w;
   endfunction

   task automatic test_reset_state();
      bus_word(OP_READ, 12'h000, 32'd0);
      bus_word(OP_READ, 12'h7F4, 32'd0);
      bus_word(OP_READ, 12'h7F8, 32'd0);
      bus_word(OP_READ, STAT_BASE + 12'h00C, 32'd0);
      drain_responses();
   endtask

   task automatic test_register_access();
      bus_word(OP_WRITE, 12'h000, 32'hFFFF_FFFF);
      bus_word(OP_READ, 12'h000, 32'd0);
      bus_word(OP_WRITE, 12'h7F4, 32'hA5C3_0F96);
      bus_word(OP_WRITE, 12'h7F8, 32'hFFFF_FFFF);
      bus_word(OP_READ, 12'h7F8, 32'd0);
      bus_word(OP_WRITE, 12'h008, 32'd0);
      pad_word(7'd0, 1'b1);
      bus_word(OP_READ, 12'h008, 32'd0);
      drain_responses();
   endtask

   task automatic test_bad_addresses();
      bus_word(OP_READ, 12'h001, 32'd0);
      bus_word(OP_WRITE, 12'h002, 32'hFFFF_FFFF);
      bus_word(OP_READ, 12'h00C, 32'd0);
      bus_word(OP_WRITE, 12'h7FC, 32'hFFFF_FFFF);
      bus_word(OP_READ, STAT_BASE + 12'h010, 32'd0);
      bus_word(OP_WRITE, 12'hFFF, 32'hFFFF_FFFF);
      bus_word(OP_NONE, 12'hFFC, 32'hFFFF_FFFF);
      drain_responses();
   endtask

   task automatic test_interrupts();
      bus_word(OP_WRITE, STAT_BASE, 32'hFFFF_FFFF);
      bus_word(OP_WRITE, 12'h210, 32'd1 << CONF_POS_BIT);
      pad_word(7'd33, 1'b1);
      pad_word(7'd33, 1'b1);
      bus_word(OP_WRITE, STAT_BASE + 12'h004, 32'hFFFF_FFFF);
      bus_word(OP_WRITE, 12'h210, 32'd1 << CONF_NEG_BIT);
      pad_word(7'd33, 1'b0);
      bus_word(OP_READ, STAT_BASE + 12'h004, 32'd0);
      bus_word(OP_WRITE, 12'h7F0, (32'd1 << CONF_LVL_BIT) | (32'd1 << CONF_NEG_BIT));
      pad_word(7'd127, 1'b0);
      bus_word(OP_WRITE, STAT_BASE + 12'h004, 32'hFFFF_FFFF);
      drain_responses();
   endtask

   task automatic test_random_traffic(input int count);
      gpio_word_type w;
      int         gap;
      for (int i = 0; i < count; i++) begin
         w   = random_word();
         gap = 0;
         if (i < count - 200 && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
         send_word(w, gap);
         if (i == count / 2) drain_responses();
      end
      drain_responses();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = OP_NONE;
      req_address    = 12'd0;
      req_write_data = 32'd0;
      req_pad_index  = 7'd0;
      req_pad_level  = 1'b0;
      fail_count     = 0;
      cycle_count    = 0;
      n_reads        = 0;
      n_writes       = 0;
      n_samples      = 0;
      n_other        = 0;
      n_irq_hits     = 0;
      for (int i = 0; i < NUM_PADS; i++) begin
         conf_mem[i]  = 32'd0;
         extra_mem[i] = 32'd0;
         value_mem[i] = VAL_RESET;
         last_lvl[i]  = 1'b0;
      end
      for (int i = 0; i < STAT_WORDS; i++) stat_mem[i] = 32'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_access();
      test_bad_addresses();
      test_interrupts();
      test_random_traffic(1050);

      $display("Run covered %0d bus reads, %0d bus writes, %0d pad samples and %0d idle words,",
               n_reads, n_writes, n_samples, n_other);
      $display("with %0d interrupt status bits raised by pad samples.", n_irq_hits);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: gpio_pad_controller_with_irq_core.f
hdl/gpc_pkg.sv
hdl/gpc_ctrl.sv
hdl/gpc_datapath.sv
hdl/gpio_pad_controller_with_irq_core.sv
hdl/gpc_checker.sv
tb/tb.sv
